// File: rtl/core/tbd_pkg.sv
package tbd_pkg;

   // q16.16 / q0.16 fixed point
   localparam int FRAC_BITS = 16;
   localparam int RATIO_BITS = 17;
   localparam int WEIGHT_BITS = 17;
   localparam int DROP_STEPS = 17;

   localparam logic [RATIO_BITS-1:0] ONE_Q16 = 17'h10000;
   localparam logic [12:0] DRIFT_MAX = 13'd6554;
   localparam logic [FRAC_BITS-1:0] ROUND_HALF = 16'h8000;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 17;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DURATION = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DRIFT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAL_TIME = 3'd4;

   localparam logic [16:0] THRESHOLD_RESET = 17'd131;
   localparam logic [9:0] DURATION_RESET = 10'd120;
   localparam logic [16:0] ALPHA_RESET = 17'd6554;
   localparam logic [12:0] DRIFT_RESET = 13'd7;
   localparam logic [15:0] CAL_TIME_RESET = 16'd2000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_CAL_DIV,
      ST_FILT,
      ST_BASE,
      ST_CMP,
      ST_DROP,
      ST_DECIDE,
      ST_DONE
   } state_type;

   // status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

// File: rtl/core/tbd_blend.sv
module tbd_blend import tbd_pkg::*; #(
   parameter int QW = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [WEIGHT_BITS-1:0] weight,
   input  logic [QW-1:0]          x_val,
   input  logic [QW-1:0]          y_val,
   output logic [QW-1:0]          result,
   output unit_sts_type           sts
);

   localparam int AW = QW + FRAC_BITS + 1;
   localparam int CW = $clog2(WEIGHT_BITS);

   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [WEIGHT_BITS-1:0] w_ff, w_in;
   logic [AW-1:0]          d_ff, d_in;
   logic [AW-1:0]          acc_ff, acc_in;
   logic [QW:0]            diff;

   // w*x + (1-w)*y == y + w*(x-y), one weight bit a cycle
   assign diff = {1'b0, x_val} - {1'b0, y_val};

   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      w_in = w_ff;
      d_in = d_ff;
      acc_in = acc_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         w_in = weight;
         d_in = {{(AW-QW-1){diff[QW]}}, diff};
         acc_in = {1'b0, y_val, ROUND_HALF};
      end else if (run_ff) begin
         if (w_ff[0]) begin
            acc_in = acc_ff + d_ff;
         end
         w_in = {1'b0, w_ff[WEIGHT_BITS-1:1]};
         d_in = {d_ff[AW-2:0], 1'b0};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(WEIGHT_BITS - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      d_ff <= d_in;
      acc_ff <= acc_in;
   end

   assign result = acc_ff[QW+FRAC_BITS-1:FRAC_BITS];
   assign sts.busy = run_ff;
   assign sts.done = done_ff;

endmodule

// File: rtl/core/tbd_divider.sv
module tbd_divider import tbd_pkg::*; #(
   parameter int QW = 32,
   localparam int SW = $clog2(QW + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] rem_init,
   input  logic [QW-1:0] quo_init,
   input  logic [QW-1:0] divisor,
   input  logic [SW-1:0] steps,
   output logic [QW-1:0] quotient,
   output unit_sts_type  sts
);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [SW-1:0] left_ff, left_in;
   logic [QW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [QW-1:0] dvs_ff, dvs_in;
   logic [QW:0]   partial;
   logic [QW+1:0] trial;

   // restoring division, one quotient bit a cycle
   assign partial = {rem_ff, quo_ff[QW-1]};
   assign trial = {1'b0, partial} - {2'b00, dvs_ff};

   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      left_in = left_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         left_in = steps;
         rem_in = rem_init;
         quo_in = quo_init;
         dvs_in = divisor;
      end else if (run_ff) begin
         if (trial[QW+1]) begin
            rem_in = partial[QW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end else begin
            rem_in = trial[QW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end
         left_in = left_ff - SW'(1);
         if (left_ff == SW'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign sts.busy = run_ff;
   assign sts.done = done_ff;

endmodule

// File: rtl/core/touch_baseline_detector.sv
// channel   | handshake            | payload
// request   | req_valid/req_ready  | req_sample, req_now_ms, req_recalibrate
// response  | rsp_valid/rsp_ready  | rsp_calibrated .. rsp_normalized_drop
// csr       | csr_we (no wait)     | csr_index, csr_wdata
//
// one request at a time; a calibrating request only accumulates, the one that
// closes calibration also runs the bit-serial mean division
// a calibrated request runs the filter blend in the shift-add unit (one weight bit
// a cycle), a baseline blend unless touching, and a 17-step divide when baseline > filter
// reset is synchronous and needs no clearing pass
// a new request is taken while the previous response still waits for rsp_ready
module touch_baseline_detector import tbd_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [15:0]               req_sample,
   input  logic [31:0]               req_now_ms,
   input  logic                      req_recalibrate,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_calibrated,
   output logic                      rsp_touch_active,
   output logic                      rsp_stable_touch,
   output logic [15:0]               rsp_filtered_value,
   output logic [15:0]               rsp_baseline_value,
   output logic [16:0]               rsp_normalized_drop,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int QW = SAMPLE_BITS + FRAC_BITS;
   localparam int SUMW = COUNT_BITS + SAMPLE_BITS;
   localparam int SW = $clog2(QW + 1);

   state_type state_ff, state_in;

   // configuration
   logic [16:0] cfg_thr_ff, cfg_thr_in;
   logic [9:0]  cfg_dur_ff, cfg_dur_in;
   logic [16:0] cfg_alpha_ff, cfg_alpha_in;
   logic [12:0] cfg_drift_ff, cfg_drift_in;
   logic [15:0] cfg_caltime_ff, cfg_caltime_in;

   // latched request
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [31:0]            now_ff, now_in;
   logic                   recal_ff, recal_in;

   // detector state
   logic                  is_cal_ff, is_cal_in;
   logic                  pending_ff, pending_in;
   logic [31:0]           cal_start_ff, cal_start_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SUMW-1:0]       sum_ff, sum_in;
   logic [QW-1:0]         filtered_ff, filtered_in;
   logic [QW-1:0]         baseline_ff, baseline_in;
   logic                  touch_ff, touch_in;
   logic                  stable_ff, stable_in;
   logic [31:0]           touch_start_ff, touch_start_in;
   logic [16:0]           drop_ff, drop_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_cal_ff, rsp_cal_in;
   logic        rsp_touch_ff, rsp_touch_in;
   logic        rsp_stable_ff, rsp_stable_in;
   logic [15:0] rsp_filt_ff, rsp_filt_in;
   logic [15:0] rsp_base_ff, rsp_base_in;
   logic [16:0] rsp_drop_ff, rsp_drop_in;

   // combinational
   logic                   accept;
   logic                   cal_mode;
   logic [31:0]            start_eff;
   logic [31:0]            cal_elapsed;
   logic                   cal_over;
   logic [COUNT_BITS-1:0]  count_base, count_new;
   logic [SUMW-1:0]        sum_base, sum_new;
   logic [SAMPLE_BITS+15:0] sample_wide;
   logic [QW-1:0]          s16;
   logic [WEIGHT_BITS-1:0] alpha_eff, drift_eff;
   logic [QW-1:0]          one_wide;
   logic                   b_gt_f;
   logic [QW-1:0]          diff_bf, denom;
   logic [16:0]            drop_clamped;
   logic                   touch_hit;
   logic [31:0]            ts_eff, held;
   logic                   stable_hit;
   logic [QW+15:0]         filt_wide, base_wide;
   logic                   rsp_load;

   // arithmetic units
   logic                   mul_start, mul_sel_base;
   logic [WEIGHT_BITS-1:0] mul_w;
   logic [QW-1:0]          mul_x, mul_y, mul_result;
   unit_sts_type           mul_sts;
   logic                   div_start, div_sel_drop;
   logic [QW-1:0]          div_rem, div_quo, div_dvs, div_result;
   logic [SW-1:0]          div_steps;
   unit_sts_type           div_sts;

   assign accept = req_valid && req_ready;
   assign sample_wide = {{SAMPLE_BITS{1'b0}}, req_sample};

   // calibration bookkeeping, recalibrate folded in
   assign cal_mode = recal_ff || !is_cal_ff;
   assign start_eff = (recal_ff || pending_ff) ? now_ff : cal_start_ff;
   assign cal_elapsed = now_ff - start_eff;
   assign cal_over = cal_elapsed >= {16'h0000, cfg_caltime_ff};
   assign count_base = recal_ff ? '0 : count_ff;
   assign sum_base = recal_ff ? '0 : sum_ff;

   always_comb begin
      count_new = count_base;
      sum_new = sum_base;
      // saturating count: a full counter stops summing too
      if (count_base != '1) begin
         count_new = count_base + COUNT_BITS'(1);
         sum_new = sum_base + SUMW'(sample_ff);
      end
   end

   assign s16 = {sample_ff, {FRAC_BITS{1'b0}}};
   assign alpha_eff = (cfg_alpha_ff > ONE_Q16) ? ONE_Q16 : cfg_alpha_ff;
   assign drift_eff = (cfg_drift_ff > DRIFT_MAX) ? {4'h0, DRIFT_MAX} : {4'h0, cfg_drift_ff};

   // normalized drop operands
   assign one_wide = QW'(ONE_Q16);
   assign b_gt_f = baseline_ff > filtered_ff;
   assign diff_bf = baseline_ff - filtered_ff;
   assign denom = (baseline_ff > one_wide) ? baseline_ff : one_wide;
   assign drop_clamped = (div_result > one_wide) ? ONE_Q16 : div_result[16:0];

   // touch timing
   assign touch_hit = drop_ff >= cfg_thr_ff;
   assign ts_eff = touch_ff ? touch_start_ff : now_ff;
   assign held = now_ff - ts_eff;
   assign stable_hit = held >= {22'h000000, cfg_dur_ff};

   assign filt_wide = {16'h0000, filtered_ff};
   assign base_wide = {16'h0000, baseline_ff};

   // blend operands: filter in prep, baseline drift right after the filter unless touching
   assign mul_w = mul_sel_base ? drift_eff : alpha_eff;
   assign mul_x = mul_sel_base ? mul_result : s16;
   assign mul_y = mul_sel_base ? baseline_ff : ((filtered_ff == '0) ? s16 : filtered_ff);

   // divide operands: calibration mean or drop ratio
   // the quotient of the drop fits 17 bits, so the first bits are preloaded
   assign div_rem = div_sel_drop ? {1'b0, diff_bf[QW-1:1]}
                                 : QW'(sum_new[SUMW-1:SAMPLE_BITS]);
   assign div_quo = div_sel_drop ? {diff_bf[0], {(QW-1){1'b0}}}
                                 : {sum_new[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
   assign div_dvs = div_sel_drop ? denom : QW'(count_new);
   assign div_steps = div_sel_drop ? SW'(DROP_STEPS) : SW'(QW);

   tbd_blend #(
      .QW(QW)
   ) u_blend (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .weight (mul_w),
      .x_val  (mul_x),
      .y_val  (mul_y),
      .result (mul_result),
      .sts    (mul_sts)
   );

   tbd_divider #(
      .QW(QW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .quo_init (div_quo),
      .divisor  (div_dvs),
      .steps    (div_steps),
      .quotient (div_result),
      .sts      (div_sts)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (cal_mode) begin
               state_in = cal_over ? ST_CAL_DIV : ST_DONE;
            end else begin
               state_in = ST_FILT;
            end
         end
         ST_CAL_DIV: begin
            if (div_sts.done) begin
               state_in = ST_DONE;
            end
         end
         ST_FILT: begin
            if (mul_sts.done) begin
               state_in = touch_ff ? ST_CMP : ST_BASE;
            end
         end
         ST_BASE: begin
            if (mul_sts.done) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = b_gt_f ? ST_DROP : ST_DECIDE;
         end
         ST_DROP: begin
            if (div_sts.done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      mul_start = 1'b0;
      mul_sel_base = 1'b0;
      div_start = 1'b0;
      div_sel_drop = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_PREP: begin
            mul_start = !cal_mode;
            div_start = cal_mode && cal_over;
         end
         ST_FILT: begin
            mul_sel_base = 1'b1;
            mul_start = mul_sts.done && !touch_ff;
         end
         ST_CMP: begin
            div_sel_drop = 1'b1;
            div_start = b_gt_f;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      cfg_thr_in = cfg_thr_ff;
      cfg_dur_in = cfg_dur_ff;
      cfg_alpha_in = cfg_alpha_ff;
      cfg_drift_in = cfg_drift_ff;
      cfg_caltime_in = cfg_caltime_ff;
      sample_in = sample_ff;
      now_in = now_ff;
      recal_in = recal_ff;
      is_cal_in = is_cal_ff;
      pending_in = pending_ff;
      cal_start_in = cal_start_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      filtered_in = filtered_ff;
      baseline_in = baseline_ff;
      touch_in = touch_ff;
      stable_in = stable_ff;
      touch_start_in = touch_start_ff;
      drop_in = drop_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: cfg_thr_in = csr_wdata;
            CSR_DURATION:  cfg_dur_in = csr_wdata[9:0];
            CSR_ALPHA:     cfg_alpha_in = csr_wdata;
            CSR_DRIFT:     cfg_drift_in = csr_wdata[12:0];
            CSR_CAL_TIME:  cfg_caltime_in = csr_wdata[15:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = sample_wide[SAMPLE_BITS-1:0];
               now_in = req_now_ms;
               recal_in = req_recalibrate;
            end
         end
         ST_PREP: begin
            drop_in = '0;
            if (cal_mode) begin
               if (recal_ff) begin
                  is_cal_in = 1'b0;
                  touch_in = 1'b0;
                  stable_in = 1'b0;
                  touch_start_in = '0;
               end
               pending_in = 1'b0;
               cal_start_in = start_eff;
               count_in = count_new;
               sum_in = sum_new;
            end
         end
         ST_CAL_DIV: begin
            if (div_sts.done) begin
               baseline_in = div_result;
               filtered_in = div_result;
               is_cal_in = 1'b1;
               count_in = '0;
               sum_in = '0;
            end
         end
         ST_FILT: begin
            if (mul_sts.done) begin
               filtered_in = mul_result;
            end
         end
         ST_BASE: begin
            if (mul_sts.done) begin
               baseline_in = mul_result;
            end
         end
         ST_DROP: begin
            if (div_sts.done) begin
               drop_in = drop_clamped;
            end
         end
         ST_DECIDE: begin
            if (touch_hit) begin
               touch_in = 1'b1;
               touch_start_in = ts_eff;
               if (!stable_ff && stable_hit) begin
                  stable_in = 1'b1;
               end
            end else begin
               touch_in = 1'b0;
               stable_in = 1'b0;
               touch_start_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // response register, parts the result from the next request
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_cal_in = rsp_cal_ff;
      rsp_touch_in = rsp_touch_ff;
      rsp_stable_in = rsp_stable_ff;
      rsp_filt_in = rsp_filt_ff;
      rsp_base_in = rsp_base_ff;
      rsp_drop_in = rsp_drop_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_cal_in = is_cal_ff;
         rsp_touch_in = touch_ff;
         rsp_stable_in = stable_ff;
         rsp_filt_in = filt_wide[FRAC_BITS+15:FRAC_BITS];
         rsp_base_in = base_wide[FRAC_BITS+15:FRAC_BITS];
         rsp_drop_in = drop_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cfg_thr_ff <= THRESHOLD_RESET;
         cfg_dur_ff <= DURATION_RESET;
         cfg_alpha_ff <= ALPHA_RESET;
         cfg_drift_ff <= DRIFT_RESET;
         cfg_caltime_ff <= CAL_TIME_RESET;
         is_cal_ff <= 1'b0;
         pending_ff <= 1'b1;
         cal_start_ff <= '0;
         count_ff <= '0;
         sum_ff <= '0;
         filtered_ff <= '0;
         baseline_ff <= '0;
         touch_ff <= 1'b0;
         stable_ff <= 1'b0;
         touch_start_ff <= '0;
         drop_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cfg_thr_ff <= cfg_thr_in;
         cfg_dur_ff <= cfg_dur_in;
         cfg_alpha_ff <= cfg_alpha_in;
         cfg_drift_ff <= cfg_drift_in;
         cfg_caltime_ff <= cfg_caltime_in;
         is_cal_ff <= is_cal_in;
         pending_ff <= pending_in;
         cal_start_ff <= cal_start_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         filtered_ff <= filtered_in;
         baseline_ff <= baseline_in;
         touch_ff <= touch_in;
         stable_ff <= stable_in;
         touch_start_ff <= touch_start_in;
         drop_ff <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      now_ff <= now_in;
      recal_ff <= recal_in;
      rsp_cal_ff <= rsp_cal_in;
      rsp_touch_ff <= rsp_touch_in;
      rsp_stable_ff <= rsp_stable_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_base_ff <= rsp_base_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_calibrated = rsp_cal_ff;
   assign rsp_touch_active = rsp_touch_ff;
   assign rsp_stable_touch = rsp_stable_ff;
   assign rsp_filtered_value = rsp_filt_ff;
   assign rsp_baseline_value = rsp_base_ff;
   assign rsp_normalized_drop = rsp_drop_ff;

`ifndef SYNTHESIS
   // shared units are only launched when idle
   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_sts.busy)
      else $error("blend unit started while busy");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy)
      else $error("divider started while busy");

   // stable touch only exists with touch, and touch only after calibration
   a_stable_needs_touch: assert property (@(posedge clock) disable iff (reset)
      stable_ff |-> touch_ff)
      else $error("stable touch without touch");

   a_touch_needs_cal: assert property (@(posedge clock) disable iff (reset)
      touch_ff |-> is_cal_ff)
      else $error("touch flagged while uncalibrated");

   // drop never exceeds one when the threshold is compared
   a_drop_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (drop_ff <= ONE_Q16))
      else $error("normalized drop out of range");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tbd_pkg::*;

   // an index that maps to no register, writes there must change nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 3'd7;
   // calibration counter saturates here
   localparam int COUNT_LIMIT = 65535;

   typedef struct packed {
      logic        calibrated;
      logic        touch_active;
      logic        stable_touch;
      logic [15:0] filtered_value;
      logic [15:0] baseline_value;
      logic [16:0] normalized_drop;
   } touch_status_t;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [15:0]               req_sample;
   logic [31:0]               req_now_ms;
   logic                      req_recalibrate;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_calibrated;
   logic                      rsp_touch_active;
   logic                      rsp_stable_touch;
   logic [15:0]               rsp_filtered_value;
   logic [15:0]               rsp_baseline_value;
   logic [16:0]               rsp_normalized_drop;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   touch_baseline_detector u_top (.*);

   // register copies kept in step with every csr write
   logic [16:0] thr_q      = THRESHOLD_RESET;
   logic [9:0]  dur_ms     = DURATION_RESET;
   logic [16:0] alpha_q    = ALPHA_RESET;
   logic [12:0] drift_q    = DRIFT_RESET;
   logic [15:0] cal_time   = CAL_TIME_RESET;

   // detector state as it stands after the last accepted request
   logic        cal_done    = 1'b0;
   logic        cal_pending = 1'b1;
   logic [31:0] cal_start   = '0;
   logic [15:0] cal_count   = '0;
   logic [47:0] cal_sum     = '0;
   logic [31:0] filt_q      = '0;
   logic [31:0] base_q      = '0;
   logic        touching    = 1'b0;
   logic        stable      = 1'b0;
   logic [31:0] touch_t0    = '0;

   // status words still owed by the block, oldest first
   touch_status_t pending_status[$];

   int          error_count    = 0;
   int          update_count   = 0;
   int          result_count   = 0;
   int          settings_count = 0;
   int          cal_closes     = 0;
   int          touch_starts   = 0;
   int          stable_hits    = 0;
   int          recal_count    = 0;
   int          ready_hold     = 0;
   bit          idle_en        = 1'b1;
   logic [31:0] stamp_ms       = '0;

   // 125 MHz
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #40_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // q0.16 weighted mix of two q16.16 values, rounded half up
   function automatic logic [31:0] mix_q16(input logic [16:0] w, input logic [31:0] x,
                                           input logic [31:0] y);
      logic [63:0] acc;
      acc = 64'(w) * 64'(x) + (64'(ONE_Q16) - 64'(w)) * 64'(y) + 64'd32768;
      return acc[47:16];
   endfunction

   // advance the detector by one update and return the status it must report
   function automatic touch_status_t track_update(input logic [15:0] sample,
                                                  input logic [31:0] now,
                                                  input logic recal);
      logic [31:0]   elapsed;
      logic [31:0]   held;
      logic [16:0]   alpha;
      logic [16:0]   drift;
      logic [63:0]   mean;
      logic [63:0]   denom;
      logic [63:0]   drop;
      touch_status_t st;
      drop = '0;
      if (recal) begin
         recal_count++;
         cal_done = 1'b0;
         cal_pending = 1'b0;
         cal_start = now;
         cal_count = '0;
         cal_sum = '0;
         touching = 1'b0;
         stable = 1'b0;
         touch_t0 = '0;
      end
      if (!cal_done) begin
         // first update after reset opens the calibration window
         if (cal_pending) begin
            cal_start = now;
            cal_pending = 1'b0;
         end
         elapsed = now - cal_start;
         if (cal_count != 16'(COUNT_LIMIT)) begin
            cal_sum += 48'(sample);
            cal_count++;
         end
         if (elapsed >= 32'(cal_time)) begin
            mean = {cal_sum, 16'h0} / 64'(cal_count);
            base_q = mean[31:0];
            filt_q = mean[31:0];
            cal_done = 1'b1;
            cal_count = '0;
            cal_sum = '0;
            cal_closes++;
         end
      end else begin
         alpha = (alpha_q > ONE_Q16) ? ONE_Q16 : alpha_q;
         drift = (drift_q > DRIFT_MAX) ? 17'(DRIFT_MAX) : 17'(drift_q);
         if (filt_q == '0)
            filt_q = {sample, 16'h0};
         filt_q = mix_q16(alpha, {sample, 16'h0}, filt_q);
         if (!touching)
            base_q = mix_q16(drift, filt_q, base_q);
         denom = (base_q > 32'(ONE_Q16)) ? 64'(base_q) : 64'(ONE_Q16);
         if (base_q > filt_q) begin
            drop = {16'h0, base_q - filt_q, 16'h0} / denom;
            if (drop > 64'(ONE_Q16))
               drop = 64'(ONE_Q16);
         end
         if (drop >= 64'(thr_q)) begin
            if (!touching) begin
               touching = 1'b1;
               touch_t0 = now;
               touch_starts++;
            end
            held = now - touch_t0;
            if (!stable && held >= 32'(dur_ms)) begin
               stable = 1'b1;
               stable_hits++;
            end
         end else begin
            touching = 1'b0;
            stable = 1'b0;
            touch_t0 = '0;
         end
      end
      st.calibrated = cal_done;
      st.touch_active = touching;
      st.stable_touch = stable;
      st.filtered_value = filt_q[31:16];
      st.baseline_value = base_q[31:16];
      st.normalized_drop = drop[16:0];
      return st;
   endfunction

   function automatic void check_field(input string name, input logic [16:0] want,
                                       input logic [16:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // one request; valid stays up into the next request when no gap is drawn
   task automatic send_update(input logic [15:0] sample, input logic [31:0] now,
                              input logic recal);
      int gap;
      req_valid <= 1'b1;
      req_sample <= sample;
      req_now_ms <= now;
      req_recalibrate <= recal;
      do @(posedge clock); while (!req_ready);
      pending_status.push_back(track_update(sample, now, recal));
      update_count++;
      gap = idle_en ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off requests until every owed response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_status.size() != 0);
   endtask

   // all five registers back to back, then a write to the unused index
   task automatic apply_settings(input logic [16:0] thr, input logic [9:0] dur,
                                 input logic [16:0] alpha, input logic [12:0] drift,
                                 input logic [15:0] cal);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      csr_index <= CSR_DURATION;
      csr_wdata <= CSR_DATA_BITS'(dur);
      @(posedge clock);
      csr_index <= CSR_ALPHA;
      csr_wdata <= alpha;
      @(posedge clock);
      csr_index <= CSR_DRIFT;
      csr_wdata <= CSR_DATA_BITS'(drift);
      @(posedge clock);
      csr_index <= CSR_CAL_TIME;
      csr_wdata <= CSR_DATA_BITS'(cal);
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= CSR_DATA_BITS'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      thr_q = thr;
      dur_ms = dur;
      alpha_q = alpha;
      drift_q = drift;
      cal_time = cal;
      settings_count++;
   endtask

   // reset register values: 2000 ms calibration, then a touch that turns stable
   task automatic test_reset_values();
      stamp_ms = $urandom;
      send_update(16'd1000, stamp_ms, 1'b0);
      stamp_ms += 700;
      send_update(16'd1010, stamp_ms, 1'b0);
      stamp_ms += 700;
      send_update(16'd990, stamp_ms, 1'b0);
      // 2100 ms elapsed closes calibration
      stamp_ms += 700;
      send_update(16'd1000, stamp_ms, 1'b0);
      repeat (5) begin
         stamp_ms += 50;
         send_update(16'd900, stamp_ms, 1'b0);
      end
      // recalibrate in the middle of a held touch
      stamp_ms += 50;
      send_update(16'd900, stamp_ms, 1'b1);
   endtask

   // zero calibration time, one ms calibration across the timestamp wrap
   task automatic test_calibration_edges();
      apply_settings(THRESHOLD_RESET, DURATION_RESET, ALPHA_RESET, DRIFT_RESET, 16'd0);
      stamp_ms = $urandom;
      send_update(16'hFFFF, stamp_ms, 1'b1);
      send_update(16'hFFFF, stamp_ms + 1, 1'b0);
      apply_settings(THRESHOLD_RESET, DURATION_RESET, ALPHA_RESET, DRIFT_RESET, 16'd1);
      send_update(16'h0000, 32'hFFFF_FFFF, 1'b1);
      send_update(16'hFFFF, 32'h0000_0000, 1'b0);
   endtask

   // baseline of exactly 1.0, filter collapsing to zero, full-scale drop
   task automatic test_zero_filter();
      apply_settings(ONE_Q16, 10'd0, ONE_Q16, 13'd0, 16'd1);
      stamp_ms = $urandom;
      send_update(16'd0, stamp_ms, 1'b1);
      send_update(16'd2, stamp_ms + 1, 1'b0);
      send_update(16'd0, stamp_ms + 2, 1'b0);
      // filter sits at zero, gets reloaded from the sample
      send_update(16'd0, stamp_ms + 3, 1'b0);
      send_update(16'd3, stamp_ms + 4, 1'b0);
   endtask

   // out-of-range alpha, drift and threshold; zero threshold; longest duration
   task automatic test_ratio_clamps();
      apply_settings(17'h1FFFF, 10'h3FF, 17'h1FFFF, 13'h1FFF, 16'd1);
      send_update(16'd5000, 32'hFFFF_FF00, 1'b1);
      send_update(16'd5000, 32'hFFFF_FF01, 1'b0);
      send_update(16'd100, 32'hFFFF_FF02, 1'b0);
      apply_settings(17'd0, 10'h3FF, 17'h1FFFF, 13'h1FFF, 16'd1);
      send_update(16'd100, 32'hFFFF_FF10, 1'b0);
      // hold time wraps through zero, one ms short and then exactly reached
      send_update(16'd100, 32'h0000_030E, 1'b0);
      send_update(16'd100, 32'h0000_030F, 1'b0);
   endtask

   // more samples than the counter holds, all inside one calibration window
   task automatic test_count_saturation();
      idle_en = 1'b0;
      apply_settings(THRESHOLD_RESET, DURATION_RESET, ALPHA_RESET, DRIFT_RESET, 16'hFFFF);
      stamp_ms = $urandom;
      send_update(16'($urandom), stamp_ms, 1'b1);
      repeat (COUNT_LIMIT + 2)
         send_update(16'($urandom), stamp_ms + $urandom_range(0, 65534), 1'b0);
      send_update(16'($urandom), stamp_ms + 32'd65535, 1'b0);
      send_update(16'($urandom), stamp_ms + 32'd65536, 1'b0);
      idle_en = 1'b1;
   endtask

   // settings drawn per phase, quiet stretches alternating with presses
   task automatic test_random_traffic();
      logic [16:0] thr;
      logic [9:0]  dur;
      logic [16:0] alpha;
      logic [12:0] drift;
      logic [15:0] cal;
      int unsigned level;
      int unsigned depth;
      int          quiet;
      int          pressed;
      int          k;
      longint      s;
      logic [31:0] step;
      logic        recal;
      for (int phase = 0; phase < 10; phase++) begin
         case ($urandom_range(0, 7))
            0: thr = '0;
            1: thr = ONE_Q16;
            2: thr = 17'($urandom_range(65537, 131071));
            default: thr = 17'($urandom_range(60, 4000));
         endcase
         case ($urandom_range(0, 5))
            0: dur = '0;
            1: dur = 10'h3FF;
            default: dur = 10'($urandom_range(30, 300));
         endcase
         case ($urandom_range(0, 9))
            0: alpha = '0;
            1: alpha = ONE_Q16;
            2: alpha = 17'($urandom_range(65537, 131071));
            default: alpha = 17'($urandom_range(2000, 40000));
         endcase
         case ($urandom_range(0, 7))
            0: drift = '0;
            1: drift = DRIFT_MAX;
            2: drift = 13'($urandom_range(6555, 8191));
            default: drift = 13'($urandom_range(0, 300));
         endcase
         case ($urandom_range(0, 7))
            0: cal = '0;
            1: cal = 16'd1;
            2: cal = 16'hFFFF;
            default: cal = 16'($urandom_range(2, 400));
         endcase
         // some phases run with no gaps on either side
         idle_en = (phase % 4) != 2;
         apply_settings(thr, dur, alpha, drift, cal);
         case ($urandom_range(0, 5))
            0: level = $urandom_range(0, 3);
            1: level = 65535;
            default: level = $urandom_range(300, 60000);
         endcase
         recal = ($urandom_range(0, 3) != 0);
         k = 0;
         while (k < 80) begin
            quiet = $urandom_range(2, 12);
            pressed = $urandom_range(1, 20);
            for (int j = 0; j < quiet + pressed; j++) begin
               // press depth as a q0.16 fraction of the level
               if (j < quiet)
                  depth = 0;
               else if ($urandom_range(0, 5) == 0)
                  depth = $urandom_range(0, 65535);
               else
                  depth = $urandom_range(0, 6000);
               s = longint'(level) - ((longint'(level) * longint'(depth)) >>> 16)
                   + longint'($urandom_range(0, 6)) - 3;
               if (s < 0)
                  s = 0;
               if (s > 65535)
                  s = 65535;
               if ($urandom_range(0, 29) == 0)
                  s = $urandom_range(0, 65535);
               // calibration needs a few updates to span its window
               if (!cal_done)
                  step = $urandom_range(0, int'(cal_time) / 4 + 1);
               else if ($urandom_range(0, 49) == 0)
                  step = $urandom;
               else
                  step = $urandom_range(0, 40);
               stamp_ms += step;
               send_update(16'(s), stamp_ms, recal || ($urandom_range(0, 59) == 0));
               recal = 1'b0;
            end
            k += quiet + pressed;
            // now and then let the response side empty out completely
            if ($urandom_range(0, 3) == 0)
               wait_drained();
         end
      end
   endtask

   // response side: random stall after each taken response while idle_en is set
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            ready_hold = idle_en ? $urandom_range(0, 16) : 0;
            if (ready_hold > 0)
               rsp_ready <= 1'b0;
         end else if (ready_hold > 0) begin
            ready_hold--;
            if (ready_hold == 0)
               rsp_ready <= 1'b1;
         end
      end
   end

   // compare every taken response against the oldest owed status
   always @(posedge clock) begin
      touch_status_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = pending_status.pop_front();
            result_count++;
            check_field("calibrated", want.calibrated, rsp_calibrated);
            check_field("touch_active", want.touch_active, rsp_touch_active);
            check_field("stable_touch", want.stable_touch, rsp_stable_touch);
            check_field("filtered_value", want.filtered_value, rsp_filtered_value);
            check_field("baseline_value", want.baseline_value, rsp_baseline_value);
            check_field("normalized_drop", want.normalized_drop, rsp_normalized_drop);
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample <= '0;
      req_now_ms <= '0;
      req_recalibrate <= 1'b0;
      rsp_ready <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_calibration_edges();
      test_zero_filter();
      test_ratio_clamps();
      test_count_saturation();
      test_random_traffic();

      // drain, then give a stray response time to show up
      wait_drained();
      repeat (120) @(posedge clock);

      $display("run: %0d requests, %0d responses compared, %0d register sets",
               update_count, result_count, settings_count);
      $display("seen: %0d calibrations closed, %0d recalibrations, %0d touches, %0d stable",
               cal_closes, recal_count, touch_starts, stable_hits);
      if (error_count == 0 && pending_status.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/core/tbd_pkg.sv
rtl/core/tbd_blend.sv
rtl/core/tbd_divider.sv
rtl/core/touch_baseline_detector.sv
tb/tb_top.sv
